// ----- design/ott_pkg.sv -----
// Shared types and constants of the open transaction table.
`default_nettype none
package ott_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int MAX_PEERS   = 4;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = $clog2(NUM_ENTRIES);
  localparam int PJ_W        = $clog2(MAX_PEERS);
  localparam int CNT_W       = 5;
  localparam int ID_W        = 32;
  localparam int TIME_W      = 48;
  localparam int PEER_W      = 31;
  localparam int PC_W        = 3;

  // Operation codes.
  localparam logic [3:0] K_MINT       = 4'd0;
  localparam logic [3:0] K_OPEN       = 4'd1;
  localparam logic [3:0] K_IS_OPEN    = 4'd2;
  localparam logic [3:0] K_ADMITS     = 4'd3;
  localparam logic [3:0] K_ADDRESSED  = 4'd4;
  localparam logic [3:0] K_CLOSE      = 4'd5;
  localparam logic [3:0] K_EXPIRE     = 4'd6;
  localparam logic [3:0] K_WAIT_PEER  = 4'd7;
  localparam logic [3:0] K_DRAIN      = 4'd8;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef logic [MAX_PEERS-1:0][PEER_W-1:0] peer_vec_t;

  // One stored table row.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [PC_W-1:0]   pc;
    peer_vec_t         peers;
  } entry_row_t;

  // Keys presented to the compare unit.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tv;
    logic [PEER_W-1:0] peer;
    logic [ID_W-1:0]   best_id;
  } cmp_key_t;

  // Compare unit results.
  typedef struct packed {
    logic id_eq;
    logic dl_le;
    logic id_lt;
    logic peer_hit;
  } cmp_res_t;

endpackage
`default_nettype wire

// ----- design/open_transaction_table_unit.sv -----
// Open transaction table: top level with the operation sequencer.
// An operation is taken while busy is low. Mint and unknown kinds answer in
// the cycle after they are taken. Every other kind walks the 16-entry memory
// one slot at a time (read, then compare), and addressed then lists the
// row's peers one per cycle. Expire, wait-for-peer and drain first mark the
// matching slots in one walk, then run one walk per listed id to find the
// smallest remaining id: up to 17 walks. Results are strobed by out_valid
// for one cycle and cannot be held off.
`default_nettype none
module open_transaction_table_unit import ott_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [3:0]        in_kind,
  input  wire logic [ID_W-1:0]   in_txn_id,
  input  wire logic [TIME_W-1:0] in_time_value,
  input  wire logic [PC_W-1:0]   in_peer_count,
  input  wire logic [PEER_W-1:0] in_peer_a,
  input  wire logic [PEER_W-1:0] in_peer_b,
  input  wire logic [PEER_W-1:0] in_peer_c,
  input  wire logic [PEER_W-1:0] in_peer_d,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic                   out_answer,
  output logic [ID_W-1:0]        out_txn_id,
  output logic [PEER_W-1:0]      out_peer,
  output logic                   out_last,
  output logic [CNT_W-1:0]       out_open_count
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EV   = 5'b00100,
    S_DONE = 5'b01000,
    S_ADDR = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    PH_FIND = 3'b001,
    PH_MARK = 3'b010,
    PH_SEL  = 3'b100
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [3:0]             kind_r, kind_nxt;
  logic [ID_W-1:0]        id_r, id_nxt;
  logic [TIME_W-1:0]      tv_r, tv_nxt;
  logic [PC_W-1:0]        pc_r, pc_nxt;
  peer_vec_t              peers_r, peers_nxt;
  logic [SLOT_W-1:0]      idx_r, idx_nxt;
  logic                   found_r, found_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [SLOT_W-1:0]      free_r, free_nxt;
  logic                   hit_r, hit_nxt;
  logic [PC_W-1:0]        row_pc_r, row_pc_nxt;
  peer_vec_t              row_peers_r, row_peers_nxt;
  logic [NUM_ENTRIES-1:0] mark_r, mark_nxt;
  logic                   best_found_r, best_found_nxt;
  logic [SLOT_W-1:0]      best_r, best_nxt;
  logic [ID_W-1:0]        best_id_r, best_id_nxt;
  logic [CNT_W-1:0]       nres_r, nres_nxt;
  logic [NUM_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [ID_W-1:0]        next_id_r, next_id_nxt;
  logic [PJ_W-1:0]        pj_r, pj_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_status_r, out_status_nxt;
  logic                   out_answer_r, out_answer_nxt;
  logic [ID_W-1:0]        out_txn_id_r, out_txn_id_nxt;
  logic [PEER_W-1:0]      out_peer_r, out_peer_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [CNT_W-1:0]       out_cnt_r;

  logic       mem_we;
  entry_row_t mem_wdata;
  entry_row_t rdata;
  cmp_key_t   key;
  cmp_res_t   cres;

  // Scan-step helper signals.
  logic                   last_slot;
  logic                   slot_valid;
  logic                   take;
  logic                   fin_found;
  logic [SLOT_W-1:0]      fin_slot;
  logic [ID_W-1:0]        fin_id;
  logic [NUM_ENTRIES-1:0] remain;
  logic                   mark_hit;
  logic [SLOT_W-1:0]      wslot;

  assign busy = (state_r != S_IDLE);

  ott_entry_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wslot),
    .wdata (mem_wdata),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign key.id      = id_r;
  assign key.tv      = tv_r;
  assign key.peer    = peers_r[0];
  assign key.best_id = best_id_r;

  ott_cmp_unit u_cmp (
    .row (rdata),
    .key (key),
    .res (cres)
  );

  assign mem_wdata.id       = id_r;
  assign mem_wdata.deadline = tv_r;
  assign mem_wdata.pc       = pc_r;
  assign mem_wdata.peers    = peers_r;
  assign wslot              = found_r ? slot_r : free_r;

  assign last_slot  = (idx_r == SLOT_W'(NUM_ENTRIES - 1));
  assign slot_valid = valid_r[idx_r];
  assign take       = mark_r[idx_r] && (!best_found_r || cres.id_lt);
  assign fin_found  = best_found_r || take;
  assign fin_slot   = take ? idx_r : best_r;
  assign fin_id     = take ? rdata.id : best_id_r;
  assign remain     = mark_r & ~(NUM_ENTRIES'(1) << fin_slot);

  // Mark condition of the list operations.
  always_comb begin
    priority if (kind_r == K_EXPIRE) begin
      mark_hit = slot_valid && cres.dl_le;
    end else if (kind_r == K_WAIT_PEER) begin
      mark_hit = slot_valid && cres.peer_hit;
    end else begin
      mark_hit = slot_valid;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    id_nxt         = id_r;
    tv_nxt         = tv_r;
    pc_nxt         = pc_r;
    peers_nxt      = peers_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    slot_nxt       = slot_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    hit_nxt        = hit_r;
    row_pc_nxt     = row_pc_r;
    row_peers_nxt  = row_peers_r;
    mark_nxt       = mark_r;
    best_found_nxt = best_found_r;
    best_nxt       = best_r;
    best_id_nxt    = best_id_r;
    nres_nxt       = nres_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    next_id_nxt    = next_id_r;
    pj_nxt         = pj_r;
    mem_we         = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ST_OK;
    out_answer_nxt = 1'b0;
    out_txn_id_nxt = '0;
    out_peer_nxt   = '0;
    out_last_nxt   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt       = in_kind;
          id_nxt         = in_txn_id;
          tv_nxt         = in_time_value;
          pc_nxt         = (in_peer_count > PC_W'(MAX_PEERS)) ? PC_W'(MAX_PEERS)
                                                              : in_peer_count;
          peers_nxt      = {in_peer_d, in_peer_c, in_peer_b, in_peer_a};
          idx_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          nres_nxt       = '0;
          best_found_nxt = 1'b0;
          priority if (in_kind == K_MINT) begin
            out_valid_nxt  = 1'b1;
            out_txn_id_nxt = next_id_r;
            next_id_nxt    = next_id_r + ID_W'(1);
          end else if (in_kind > K_DRAIN) begin
            out_valid_nxt = 1'b1;
          end else if (in_kind == K_EXPIRE || in_kind == K_WAIT_PEER ||
                       in_kind == K_DRAIN) begin
            phase_nxt = PH_MARK;
            state_nxt = S_RD;
          end else begin
            phase_nxt = PH_FIND;
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        state_nxt = S_EV;
      end

      S_EV: begin
        state_nxt = S_RD;
        idx_nxt   = idx_r + SLOT_W'(1);
        unique case (phase_r)
          PH_FIND: begin
            if (slot_valid && cres.id_eq && !found_r) begin
              found_nxt     = 1'b1;
              slot_nxt      = idx_r;
              hit_nxt       = cres.peer_hit;
              row_pc_nxt    = rdata.pc;
              row_peers_nxt = rdata.peers;
            end
            if (!slot_valid && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_nxt       = idx_r;
            end
            if (last_slot) begin
              state_nxt = S_DONE;
            end
          end
          PH_MARK: begin
            mark_nxt[idx_r] = mark_hit;
            if (mark_hit && kind_r != K_WAIT_PEER) begin
              valid_nxt[idx_r] = 1'b0;
              cnt_nxt          = cnt_r - CNT_W'(1);
            end
            if (last_slot) begin
              phase_nxt      = PH_SEL;
              best_found_nxt = 1'b0;
            end
          end
          PH_SEL: begin
            best_found_nxt = fin_found;
            best_nxt       = fin_slot;
            best_id_nxt    = fin_id;
            if (last_slot) begin
              out_valid_nxt  = 1'b1;
              best_found_nxt = 1'b0;
              if (fin_found) begin
                out_txn_id_nxt = fin_id;
                out_last_nxt   = (nres_r == CNT_W'(MAX_RESULTS - 1)) || (remain == '0);
                mark_nxt       = remain;
                nres_nxt       = nres_r + CNT_W'(1);
                if (out_last_nxt) begin
                  state_nxt = S_IDLE;
                end
              end else begin
                out_status_nxt = ST_EMPTY;
                state_nxt      = S_IDLE;
              end
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_DONE: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        priority if (kind_r == K_OPEN) begin
          if (found_r || free_found_r) begin
            mem_we           = 1'b1;
            valid_nxt[wslot] = 1'b1;
            if (!found_r) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end else begin
            out_status_nxt = ST_FULL;
          end
        end else if (!found_r) begin
          out_status_nxt = ST_NOT_FOUND;
        end else if (kind_r == K_IS_OPEN) begin
          out_answer_nxt = 1'b1;
        end else if (kind_r == K_ADMITS) begin
          out_answer_nxt = hit_r;
        end else if (kind_r == K_CLOSE) begin
          out_answer_nxt   = 1'b1;
          valid_nxt[slot_r] = 1'b0;
          cnt_nxt          = cnt_r - CNT_W'(1);
        end else if (row_pc_r == '0) begin
          out_status_nxt = ST_EMPTY;
          out_txn_id_nxt = id_r;
        end else begin
          // Addressed with peers: list them one per cycle.
          out_valid_nxt = 1'b0;
          pj_nxt        = '0;
          state_nxt     = S_ADDR;
        end
      end

      S_ADDR: begin
        out_valid_nxt  = 1'b1;
        out_txn_id_nxt = id_r;
        out_peer_nxt   = row_peers_r[pj_r];
        out_last_nxt   = ((PC_W'(pj_r) + PC_W'(1)) == row_pc_r);
        pj_nxt         = pj_r + PJ_W'(1);
        if (out_last_nxt) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_FIND;
      valid_r     <= '0;
      cnt_r       <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    id_r         <= id_nxt;
    tv_r         <= tv_nxt;
    pc_r         <= pc_nxt;
    peers_r      <= peers_nxt;
    idx_r        <= idx_nxt;
    found_r      <= found_nxt;
    slot_r       <= slot_nxt;
    free_found_r <= free_found_nxt;
    free_r       <= free_nxt;
    hit_r        <= hit_nxt;
    row_pc_r     <= row_pc_nxt;
    row_peers_r  <= row_peers_nxt;
    mark_r       <= mark_nxt;
    best_found_r <= best_found_nxt;
    best_r       <= best_nxt;
    best_id_r    <= best_id_nxt;
    nres_r       <= nres_nxt;
    pj_r         <= pj_nxt;
    out_status_r <= out_status_nxt;
    out_answer_r <= out_answer_nxt;
    out_txn_id_r <= out_txn_id_nxt;
    out_peer_r   <= out_peer_nxt;
    out_last_r   <= out_last_nxt;
    out_cnt_r    <= cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_answer     = out_answer_r;
  assign out_txn_id     = out_txn_id_r;
  assign out_peer       = out_peer_r;
  assign out_last       = out_last_r;
  assign out_open_count = out_cnt_r;

  // The open count always tracks the valid marks.
  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(valid_r)))
    else $error("open count differs from valid marks");

  // A result only follows an accepted operation or sequencer work.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without an operation");

  // A non-final result is always followed by more work.
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("list ended without a final result");

endmodule
`default_nettype wire

// ----- design/ott_entry_store.sv -----
// Entry memory: one write port and one registered read port.
`default_nettype none
module ott_entry_store import ott_pkg::*; (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [SLOT_W-1:0] waddr,
  input  wire entry_row_t        wdata,
  input  wire logic [SLOT_W-1:0] raddr,
  output entry_row_t             rdata
);

  entry_row_t mem [NUM_ENTRIES];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/ott_cmp_unit.sv -----
// Shared compare unit applied to one table row per step.
`default_nettype none
module ott_cmp_unit import ott_pkg::*; (
  input  wire entry_row_t row,
  input  wire cmp_key_t   key,
  output cmp_res_t        res
);

  logic [MAX_PEERS-1:0] hits;

  // Peer match over the stored peers of the row.
  always_comb begin
    for (int j = 0; j < MAX_PEERS; j++) begin
      hits[j] = (PC_W'(j) < row.pc) && (row.peers[j] == key.peer);
    end
  end

  assign res.id_eq    = (row.id == key.id);
  assign res.dl_le    = (row.deadline <= key.tv);
  assign res.id_lt    = (row.id < key.best_id);
  assign res.peer_hit = |hits;

endmodule
`default_nettype wire
